FILE: src/cptpi_pkg.sv
// Shared types and constants for the cascaded position/torque PI block.
`default_nettype none

package cptpi_pkg;

    // Q16.16 constants
    localparam logic signed [19:0] Q_PI       = 20'sd205887;
    localparam logic signed [19:0] Q_TWO_PI   = 20'sd411775;
    localparam logic signed [31:0] Q_FIVE     = 32'sd327680;
    localparam logic signed [31:0] Q_THREE    = 32'sd196608;
    localparam logic [16:0]        DT_DEFAULT = 17'd66;

    // datapath widths
    localparam int MAG_W   = 36;               // multiplier magnitude operand
    localparam int GAIN_W  = 31;               // multiplier gain operand
    localparam int PROD_W  = MAG_W + GAIN_W;   // full product
    localparam int RES_W   = PROD_W - 16 + 1;  // rounded, signed
    localparam int SUM_W   = RES_W + 1;        // accumulate before clamp
    localparam int ITERM_W = MAG_W + 1;        // saturated integral step, signed

    // configuration register reset values
    localparam logic [30:0] RST_POS_KP  = 31'd262144;
    localparam logic [30:0] RST_POS_KI  = 31'd5242880;
    localparam logic [30:0] RST_TRQ_KP  = 31'd52429;
    localparam logic [30:0] RST_TRQ_KI  = 31'd13107200;
    localparam logic [30:0] RST_TRQ_CAP = 31'd196608;
    localparam logic [16:0] RST_PERIOD  = 17'd66;

    typedef enum logic [2:0] {
        CFG_POS_KP   = 3'd0,
        CFG_POS_KI   = 3'd1,
        CFG_TRQ_KP   = 3'd2,
        CFG_TRQ_KI   = 3'd3,
        CFG_TARGET   = 3'd4,
        CFG_TRQ_CAP  = 3'd5,
        CFG_VOLT_CAP = 3'd6,
        CFG_PERIOD   = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [30:0] pos_kp;
        logic [30:0] pos_ki;
        logic [30:0] trq_kp;
        logic [30:0] trq_ki;
        logic [18:0] target_angle;
        logic [30:0] torque_cap;
        logic [22:0] volt_cap;
        logic [16:0] sample_period;
    } t_cfg;

    // one pass through the shared multiplier per step
    typedef enum logic [2:0] {
        ST_PKI = 3'd0,
        ST_PDT = 3'd1,
        ST_PKP = 3'd2,
        ST_TKI = 3'd3,
        ST_TDT = 3'd4,
        ST_TKP = 3'd5
    } t_step;

    typedef struct packed {
        logic  capture;
        logic  calc_err;
        logic  mul_en;
        logic  rnd_en;
        logic  app_en;
        logic  terr_en;
        logic  load_out;
        t_step step;
    } t_dp_cmd;

endpackage

`default_nettype wire

FILE: src/cptpi_cfg.sv
// Configuration register file for the cascaded PI block.
`default_nettype none

module cptpi_cfg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [2:0]        i_cfg_idx,
    input  logic [30:0]       i_cfg_data,
    output cptpi_pkg::t_cfg   o_cfg
);
    import cptpi_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pos_kp        <= RST_POS_KP;
            r_cfg.pos_ki        <= RST_POS_KI;
            r_cfg.trq_kp        <= RST_TRQ_KP;
            r_cfg.trq_ki        <= RST_TRQ_KI;
            r_cfg.target_angle  <= '0;
            r_cfg.torque_cap    <= RST_TRQ_CAP;
            r_cfg.volt_cap      <= '0;
            r_cfg.sample_period <= RST_PERIOD;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_POS_KP:   r_cfg.pos_kp        <= i_cfg_data;
                CFG_POS_KI:   r_cfg.pos_ki        <= i_cfg_data;
                CFG_TRQ_KP:   r_cfg.trq_kp        <= i_cfg_data;
                CFG_TRQ_KI:   r_cfg.trq_ki        <= i_cfg_data;
                CFG_TARGET:   r_cfg.target_angle  <= i_cfg_data[18:0];
                CFG_TRQ_CAP:  r_cfg.torque_cap    <= i_cfg_data;
                CFG_VOLT_CAP: r_cfg.volt_cap      <= i_cfg_data[22:0];
                CFG_PERIOD:   r_cfg.sample_period <= i_cfg_data[16:0];
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

FILE: src/cptpi_ctrl.sv
// Sequencer for the cascaded PI block: steps the shared multiplier datapath.
`default_nettype none

module cptpi_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output cptpi_pkg::t_dp_cmd  o_cmd
);
    import cptpi_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_ERR  = 7'b0000010,
        S_MUL  = 7'b0000100,
        S_RND  = 7'b0001000,
        S_APP  = 7'b0010000,
        S_TERR = 7'b0100000,
        S_FIN  = 7'b1000000
    } t_state;

    t_state  r_state, n_state;
    t_step   r_step, n_step;
    logic    r_out_valid, n_out_valid;
    t_dp_cmd w_cmd;

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        w_cmd   = '0;
        w_cmd.step = r_step;
        unique case (r_state)
            S_IDLE: begin
                w_cmd.capture = i_in_valid;
                if (i_in_valid) n_state = S_ERR;
            end
            S_ERR: begin
                w_cmd.calc_err = 1'b1;
                n_step  = ST_PKI;
                n_state = S_MUL;
            end
            S_MUL: begin
                w_cmd.mul_en = 1'b1;
                n_state = S_RND;
            end
            S_RND: begin
                w_cmd.rnd_en = 1'b1;
                n_state = S_APP;
            end
            S_APP: begin
                w_cmd.app_en = 1'b1;
                unique case (r_step)
                    ST_PKI: begin n_step = ST_PDT; n_state = S_MUL;  end
                    ST_PDT: begin n_step = ST_PKP; n_state = S_MUL;  end
                    ST_PKP: begin n_step = ST_TKI; n_state = S_TERR; end
                    ST_TKI: begin n_step = ST_TDT; n_state = S_MUL;  end
                    ST_TDT: begin n_step = ST_TKP; n_state = S_MUL;  end
                    ST_TKP: n_state = S_FIN;
                    default: n_state = S_IDLE;
                endcase
            end
            S_TERR: begin
                w_cmd.terr_en = 1'b1;
                n_state = S_MUL;
            end
            S_FIN: begin
                // hold until the output register is free
                if (!r_out_valid || i_out_ready) begin
                    w_cmd.load_out = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        if (w_cmd.load_out)  n_out_valid = 1'b1;
        else if (i_out_ready) n_out_valid = 1'b0;
        else                  n_out_valid = r_out_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= ST_PKI;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = w_cmd;

endmodule

`default_nettype wire

FILE: src/cptpi_dp.sv
// Datapath for the cascaded PI block: shared multiplier, rounding, accumulate and clamp.
`default_nettype none

module cptpi_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  cptpi_pkg::t_cfg     i_cfg,
    input  cptpi_pkg::t_dp_cmd  i_cmd,
    input  logic [18:0]         i_mech_angle,
    input  logic [18:0]         i_elec_angle,
    input  logic signed [31:0]  i_supply_volts,
    output logic signed [31:0]  o_volt_q,
    output logic signed [31:0]  o_torque_command,
    output logic [18:0]         o_angle_out
);
    import cptpi_pkg::*;

    localparam logic signed [SUM_W-1:0] ITERM_MAX =
        SUM_W'((64'd1 << (ITERM_W - 1)) - 64'd1);

    function automatic logic signed [SUM_W-1:0] f_clamp(
        input logic signed [SUM_W-1:0] v,
        input logic signed [SUM_W-1:0] lim
    );
        logic signed [SUM_W-1:0] res;
        if (v > lim)       res = lim;
        else if (v < -lim) res = -lim;
        else               res = v;
        return res;
    endfunction

    // captured item
    logic [18:0]               r_mech, r_elec;
    logic signed [31:0]        r_supply;
    // working values
    logic signed [18:0]        r_err_p;
    logic signed [32:0]        r_err_t;
    logic signed [ITERM_W-1:0] r_iterm;
    logic signed [31:0]        r_tcmd;
    logic [PROD_W-1:0]         r_prod;
    logic                      r_neg;
    logic signed [RES_W-1:0]   r_res;
    // loop state
    logic signed [31:0]        r_pint, r_tint, r_last;
    // output register
    logic signed [31:0]        r_out_vq, r_out_tc;
    logic [18:0]               r_out_ang;

    logic signed [19:0]        w_diff, w_wrap;
    logic signed [18:0]        n_err_p;
    logic [16:0]               w_dt;
    logic [30:0]               w_cap_eff;
    logic [31:0]               w_volt_lim;
    logic [18:0]               w_err_p_mag;
    logic [MAG_W-1:0]          w_iterm_mag;
    logic [32:0]               w_err_t_mag;
    logic [MAG_W-1:0]          w_mul_a;
    logic [GAIN_W-1:0]         w_mul_b;
    logic                      w_mul_neg;
    logic [PROD_W-1:0]         w_prod;
    logic [PROD_W-1:0]         w_rnd_sum;
    logic [RES_W-2:0]          w_rnd_mag;
    logic signed [RES_W-1:0]   n_res;
    logic signed [SUM_W-1:0]   w_base, w_lim, w_acc, w_clamped;

    // wrap the position error into [-pi, pi]; one step of 2*pi is enough
    always_comb begin
        w_diff = $signed({1'b0, i_cfg.target_angle}) - $signed({1'b0, r_mech});
        if (w_diff > Q_PI)       w_wrap = w_diff - Q_TWO_PI;
        else if (w_diff < -Q_PI) w_wrap = w_diff + Q_TWO_PI;
        else                     w_wrap = w_diff;
        n_err_p = w_wrap[18:0];
    end

    assign w_dt      = (i_cfg.sample_period == '0) ? DT_DEFAULT : i_cfg.sample_period;
    // torque command limit is the tighter of +-3 and the cap
    assign w_cap_eff = (i_cfg.torque_cap < 31'(Q_THREE)) ? i_cfg.torque_cap : 31'(Q_THREE);

    always_comb begin
        if (i_cfg.volt_cap != '0)    w_volt_lim = 32'(i_cfg.volt_cap);
        else if (r_supply > 32'sd0)  w_volt_lim = {1'b0, r_supply[31:1]};
        else                         w_volt_lim = '0;
    end

    assign w_err_p_mag = r_err_p[18] ? 19'(-r_err_p) : 19'(r_err_p);
    assign w_iterm_mag = r_iterm[ITERM_W-1] ? MAG_W'(-r_iterm) : r_iterm[MAG_W-1:0];
    assign w_err_t_mag = r_err_t[32] ? 33'(-r_err_t) : 33'(r_err_t);

    // operand select: sign-magnitude, gains and dt are never negative
    always_comb begin
        unique case (i_cmd.step)
            ST_PKI: begin
                w_mul_a = MAG_W'(w_err_p_mag); w_mul_b = i_cfg.pos_ki;
                w_mul_neg = r_err_p[18];
            end
            ST_PKP: begin
                w_mul_a = MAG_W'(w_err_p_mag); w_mul_b = i_cfg.pos_kp;
                w_mul_neg = r_err_p[18];
            end
            ST_PDT, ST_TDT: begin
                w_mul_a = w_iterm_mag; w_mul_b = GAIN_W'(w_dt);
                w_mul_neg = r_iterm[ITERM_W-1];
            end
            ST_TKI: begin
                w_mul_a = MAG_W'(w_err_t_mag); w_mul_b = i_cfg.trq_ki;
                w_mul_neg = r_err_t[32];
            end
            ST_TKP: begin
                w_mul_a = MAG_W'(w_err_t_mag); w_mul_b = i_cfg.trq_kp;
                w_mul_neg = r_err_t[32];
            end
            default: begin
                w_mul_a = '0; w_mul_b = '0; w_mul_neg = 1'b0;
            end
        endcase
    end

    assign w_prod = PROD_W'(w_mul_a) * PROD_W'(w_mul_b);

    // round half away from zero on the magnitude, then apply the sign
    assign w_rnd_sum = r_prod + PROD_W'(32'h8000);
    assign w_rnd_mag = w_rnd_sum[PROD_W-1:16];
    assign n_res = r_neg ? -$signed({1'b0, w_rnd_mag}) : $signed({1'b0, w_rnd_mag});

    // accumulate and clamp; integral steps only saturate
    always_comb begin
        unique case (i_cmd.step)
            ST_PKI, ST_TKI: begin w_base = '0;            w_lim = ITERM_MAX;         end
            ST_PDT:         begin w_base = SUM_W'(r_pint); w_lim = SUM_W'(Q_FIVE);    end
            ST_PKP:         begin w_base = SUM_W'(r_pint); w_lim = SUM_W'(w_cap_eff); end
            ST_TDT:         begin w_base = SUM_W'(r_tint); w_lim = SUM_W'(Q_FIVE);    end
            ST_TKP:         begin w_base = SUM_W'(r_tint); w_lim = SUM_W'(w_volt_lim); end
            default:        begin w_base = '0;            w_lim = '0;                end
        endcase
        w_acc     = SUM_W'(r_res) + w_base;
        w_clamped = f_clamp(w_acc, w_lim);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mech   <= i_mech_angle;
            r_elec   <= i_elec_angle;
            r_supply <= i_supply_volts;
        end
        if (i_cmd.calc_err) r_err_p <= n_err_p;
        if (i_cmd.mul_en) begin
            r_prod <= w_prod;
            r_neg  <= w_mul_neg;
        end
        if (i_cmd.rnd_en) r_res <= n_res;
        if (i_cmd.app_en) begin
            unique case (i_cmd.step)
                ST_PKI, ST_TKI: r_iterm <= w_clamped[ITERM_W-1:0];
                ST_PKP:         r_tcmd  <= w_clamped[31:0];
                default: ;
            endcase
        end
        if (i_cmd.terr_en) r_err_t <= 33'(r_tcmd) - 33'(r_last);
        if (i_cmd.load_out) begin
            r_out_vq  <= r_last;
            r_out_tc  <= r_tcmd;
            r_out_ang <= r_elec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pint <= '0;
            r_tint <= '0;
            r_last <= '0;
        end else if (i_cmd.app_en) begin
            unique case (i_cmd.step)
                ST_PDT:  r_pint <= w_clamped[31:0];
                ST_TDT:  r_tint <= w_clamped[31:0];
                ST_TKP:  r_last <= w_clamped[31:0];
                default: ;
            endcase
        end
    end

    assign o_volt_q         = r_out_vq;
    assign o_torque_command = r_out_tc;
    assign o_angle_out      = r_out_ang;

endmodule

`default_nettype wire

FILE: src/cascaded_position_torque_pi_top.sv
// Each item makes six passes (multiply, round, accumulate/clamp) through one shared
// 36x31 multiplier; a new item is taken only after the previous one has been loaded
// into the output register, and a stalled output holds that load until it is free.
// The next item is taken while a finished result waits in the output register.
// Reset (synchronous, active low) loads register defaults and zeroes both integrators
// and the stored q voltage.
`default_nettype none

module cascaded_position_torque_pi_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [30:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [18:0]        i_mech_angle,
    input  logic [18:0]        i_elec_angle,
    input  logic signed [31:0] i_supply_volts,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [31:0] o_volt_q,
    output logic signed [31:0] o_torque_command,
    output logic [18:0]        o_angle_out
);
    import cptpi_pkg::*;

    t_cfg    w_cfg;
    t_dp_cmd w_cmd;

    cptpi_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    cptpi_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (w_cmd)
    );

    cptpi_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (w_cfg),
        .i_cmd            (w_cmd),
        .i_mech_angle     (i_mech_angle),
        .i_elec_angle     (i_elec_angle),
        .i_supply_volts   (i_supply_volts),
        .o_volt_q         (o_volt_q),
        .o_torque_command (o_torque_command),
        .o_angle_out      (o_angle_out)
    );

endmodule

`default_nettype wire

FILE: src/cptpi_chk.sv
// Port-level checker for the cascaded PI block, bound to the top level.
`default_nettype none

module cptpi_chk (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic signed [31:0] o_volt_q,
    input logic signed [31:0] o_torque_command,
    input logic [18:0]        o_angle_out
);
    import cptpi_pkg::*;

    // a waiting result holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_volt_q)
            && $stable(o_torque_command) && $stable(o_angle_out)))
        else $error("output item changed while stalled");

    // one item in work at a time
    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("second item taken while one is in work");

    // position loop output never leaves +-3
    a_tcmd_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_torque_command <= Q_THREE && o_torque_command >= -Q_THREE))
        else $error("torque command outside +-3");

    // reset leaves no result and an idle input side
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && o_in_ready))
        else $error("block not idle after reset");

endmodule

bind cascaded_position_torque_pi_top cptpi_chk u_chk (.*);

`default_nettype wire
